[hdl/hnm_pkg.sv]
// ----------------------------------------------------------------------------
// hnm_pkg
// Shared types and constants of the height-field normal-map generator.
// ----------------------------------------------------------------------------
package hnm_pkg;

  localparam int MAX_WIDTH_DEF = 256;
  localparam logic [8:0]  WIDTH_RST   = 9'd256;
  localparam logic [15:0] DEPTH_RST   = 16'd256;
  localparam logic [15:0] SPACING_RST = 16'd256;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH   = 2'd0;
  localparam logic [1:0] REG_DEPTH   = 2'd1;
  localparam logic [1:0] REG_SPACING = 2'd2;
  localparam logic [1:0] REG_SPARE   = 2'd3;   // unmapped, writes are ignored

  // unit-length scale of Q2.14
  localparam logic [14:0] ONE_Q14 = 15'd16384;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_PREP,
    ST_NORM,
    ST_SEND
  } seq_state_t;

  // request handed to the normalizer
  typedef struct packed {
    logic signed [16:0] vx;
    logic        [16:0] vy;
    logic signed [16:0] vz;
  } norm_req_t;

  // normalized components
  typedef struct packed {
    logic signed [15:0] nx;
    logic        [14:0] ny;
    logic signed [15:0] nz;
  } norm_res_t;

endpackage

[hdl/heightfield_normal_map.sv]
// ----------------------------------------------------------------------------
// heightfield_normal_map
// Streams grid heights and gives central-difference unit normals in Q2.14.
// ----------------------------------------------------------------------------
// Channel | Direction | Content
// in_     | slave     | tdata: height[15:0]
// out_    | master    | tdata: nx, ny, nz, column, row; tlast last_of_item;
//         |           | tuser last_of_frame
// cfg_    | slave     | index[1:0], data[15:0]
// An item takes row-store reads (one read port per store, four reads), a
// set-up step before each result, then up to three normals in the shared
// normalizer (binary search per component, the midpoint squared before each
// compare), and a last set-up step that writes the height back.
// Output holds while out_tready is low; no input is taken until all results
// of the previous item have left.
// Reset is synchronous and clears counters; row stores are not cleared.
// ----------------------------------------------------------------------------
module heightfield_normal_map #(
  parameter int MAX_WIDTH = hnm_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,      // height
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,     // nx[15:0] ny[30:16] nz[46:31] column[54:47] row[70:55]
  output logic        out_tlast,     // last_of_item
  output logic        out_tuser,     // last_of_frame
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = AW + 1;

  logic [8:0]  width_r;
  logic [15:0] depth_r, spacing_r;
  logic [CW-1:0] col_r;
  logic [15:0] row_r;
  logic [15:0] prevh_r;
  logic        sel_r;
  hnm_pkg::seq_state_t st_r, st_nxt;

  logic [15:0] store_a [MAX_WIDTH];
  logic [15:0] store_b [MAX_WIDTH];
  logic [AW-1:0] ra_addr, rb_addr;
  logic [15:0] ra_q_r, rb_q_r;

  // fetched values: prev c, l, r and cur x, x-2 ; prev x-1
  logic [15:0] h_r;
  logic [15:0] p_c_r, p_l_r, p_r_r, p_m1_r, c_x_r, c_m2_r;
  logic [2:0]  rd_r;
  logic [2:0]  pend_r;      // results left to produce (bit0 first kind)
  logic        start_r;
  hnm_pkg::norm_req_t req_r;
  hnm_pkg::norm_res_t res;
  logic        ndone;
  logic [71:0] obuf_r;
  logic        olast_r, oframe_r, ovalid_r;
  logic [CW-1:0] x, wv, ocol;
  logic [15:0] d, orow;
  logic [9:0]  wfull;

  // effective width and depth
  always_comb begin
    wfull = (width_r == 9'd0) ? 10'd1 : {1'b0, width_r};
    if (int'(wfull) > MAX_WIDTH) wfull = 10'(MAX_WIDTH);
    wv = CW'(wfull);
    d = (depth_r == 16'd0) ? 16'd1 : depth_r;
    x = (col_r >= wv) ? '0 : col_r;
  end

  assign in_tready = (st_r == hnm_pkg::ST_IDLE) && !ovalid_r;
  assign cfg_ready = (st_r == hnm_pkg::ST_IDLE) && !ovalid_r;

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      hnm_pkg::ST_IDLE: if (in_tvalid && in_tready) st_nxt = hnm_pkg::ST_READ;
      hnm_pkg::ST_READ: if (rd_r == 3'd4) st_nxt = hnm_pkg::ST_PREP;
      hnm_pkg::ST_PREP: st_nxt = (pend_r == 3'd0) ? hnm_pkg::ST_IDLE : hnm_pkg::ST_NORM;
      hnm_pkg::ST_NORM: if (ndone) st_nxt = hnm_pkg::ST_SEND;
      hnm_pkg::ST_SEND: if (!ovalid_r) st_nxt = hnm_pkg::ST_PREP;
      default: st_nxt = hnm_pkg::ST_IDLE;
    endcase
  end

  // read addresses by step: 0 x, 1 x-1, 2 x+1, 3 x-2
  always_comb begin
    unique case (rd_r)
      3'd0: ra_addr = AW'(x);
      3'd1: ra_addr = AW'(x - CW'(1));
      3'd2: ra_addr = AW'(x + CW'(1));
      default: ra_addr = AW'(x - CW'(2));
    endcase
    rb_addr = ra_addr;
  end

  // row stores: registered reads, write at end of item
  always_ff @(posedge clk) begin
    ra_q_r <= store_a[ra_addr];
    rb_q_r <= store_b[rb_addr];
    if (st_r == hnm_pkg::ST_PREP && pend_r == 3'd0) begin
      if (sel_r) store_a[AW'(x)] <= h_r;
      else store_b[AW'(x)] <= h_r;
    end
  end

  // build vector for the next pending result
  hnm_pkg::norm_req_t rq;
  logic signed [15:0] hl, hr, hd, hu;
  logic lf;
  always_comb begin
    hl = '0; hr = '0; hd = '0; hu = '0; lf = 1'b0;
    ocol = x; orow = row_r;
    priority if (pend_r[0]) begin
      hl = (x > 0) ? p_l_r : p_c_r;
      hr = (x + CW'(1) < wv) ? p_r_r : p_c_r;
      hd = (row_r >= 16'd2) ? c_x_r : p_c_r;
      hu = h_r;
      orow = row_r - 16'd1;
    end else if (pend_r[1]) begin
      hl = (x >= CW'(2)) ? c_m2_r : prevh_r;
      hr = h_r;
      hd = (row_r > 0) ? p_m1_r : prevh_r;
      hu = prevh_r;
      ocol = x - CW'(1);
    end else begin
      hl = (x > 0) ? prevh_r : h_r;
      hr = h_r;
      hd = (row_r > 0) ? p_c_r : h_r;
      hu = h_r;
      lf = 1'b1;
    end
    rq.vx = 17'(hl) - 17'(hr);
    rq.vy = {spacing_r, 1'b0};
    rq.vz = 17'(hd) - 17'(hu);
  end

  hnm_normalizer u_norm (
    .clk(clk), .rst_n(rst_n), .start(start_r), .req(req_r), .done(ndone), .res(res)
  );

  logic [CW-1:0] xn;
  assign xn = x + CW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= hnm_pkg::ST_IDLE;
      width_r <= hnm_pkg::WIDTH_RST;
      depth_r <= hnm_pkg::DEPTH_RST;
      spacing_r <= hnm_pkg::SPACING_RST;
      col_r <= '0;
      row_r <= '0;
      sel_r <= 1'b0;
      prevh_r <= '0;
      ovalid_r <= 1'b0;
      start_r <= 1'b0;
      pend_r <= '0;
      rd_r <= '0;
    end else begin
      st_r <= st_nxt;
      // kick the normalizer once per issued result
      start_r <= (st_r == hnm_pkg::ST_PREP) && (pend_r != 3'd0);
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      // configuration write restarts the frame
      if (cfg_valid && cfg_ready && cfg_index <= hnm_pkg::REG_SPACING) begin
        unique case (cfg_index)
          hnm_pkg::REG_WIDTH:   width_r <= cfg_data[8:0];
          hnm_pkg::REG_DEPTH:   depth_r <= cfg_data;
          default:              spacing_r <= cfg_data;
        endcase
        col_r <= '0;
        row_r <= '0;
        sel_r <= 1'b0;
      end
      unique case (st_r)
        hnm_pkg::ST_IDLE: begin
          rd_r <= '0;
          if (in_tvalid && in_tready) begin
            h_r <= in_tdata;
            pend_r <= {(row_r + 16'd1 >= d) && (xn >= wv),
                       (row_r + 16'd1 >= d) && (x >= CW'(1)),
                       row_r >= 16'd1};
          end
        end
        hnm_pkg::ST_READ: begin
          rd_r <= rd_r + 3'd1;
          // data of step rd_r-1 arrives now
          unique case (rd_r)
            3'd1: begin
              p_c_r <= sel_r ? rb_q_r : ra_q_r;
              c_x_r <= sel_r ? ra_q_r : rb_q_r;
            end
            3'd2: begin
              p_l_r <= sel_r ? rb_q_r : ra_q_r;
              p_m1_r <= sel_r ? rb_q_r : ra_q_r;
            end
            3'd3: p_r_r <= sel_r ? rb_q_r : ra_q_r;
            3'd4: c_m2_r <= sel_r ? ra_q_r : rb_q_r;
            default: ;
          endcase
        end
        hnm_pkg::ST_PREP: begin
          if (pend_r == 3'd0) begin
            // commit item: advance counters
            prevh_r <= h_r;
            if (xn >= wv) begin
              col_r <= '0;
              sel_r <= ~sel_r;
              row_r <= (row_r + 16'd1 >= d) ? 16'd0 : row_r + 16'd1;
            end else begin
              col_r <= xn;
            end
          end else begin
            req_r <= rq;
            olast_r <= (pend_r == 3'b001) || (pend_r == 3'b010) || (pend_r == 3'b100);
            oframe_r <= lf;
            obuf_r[54:47] <= 8'(ocol);
            obuf_r[70:55] <= orow;
            priority if (pend_r[0]) pend_r[0] <= 1'b0;
            else if (pend_r[1]) pend_r[1] <= 1'b0;
            else pend_r[2] <= 1'b0;
          end
        end
        hnm_pkg::ST_NORM: begin
          if (ndone) begin
            obuf_r[15:0] <= res.nx;
            obuf_r[30:16] <= res.ny;
            obuf_r[46:31] <= res.nz;
            obuf_r[71] <= 1'b0;
            ovalid_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = obuf_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = oframe_r;

endmodule

[hdl/hnm_normalizer.sv]
// ----------------------------------------------------------------------------
// hnm_normalizer
// Exact rounded unit normal: for each component a binary search over the
// 15-bit magnitude, one compare of (2m-1)^2 * S against v^2 * 2^30 per search
// step (square the midpoint, then multiply by S in two halves and compare).
// ----------------------------------------------------------------------------
module hnm_normalizer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  hnm_pkg::norm_req_t  req,
  output logic                done,
  output hnm_pkg::norm_res_t  res
);

  // sum of squares, component magnitudes and squares
  logic [35:0] s_r, s_nxt;
  logic [16:0] m_r [3];
  logic [33:0] vv_r [3];
  logic        neg_r [3];
  logic [1:0]  comp_r, comp_nxt;
  logic [1:0]  phase_r, phase_nxt;   // 0 idle, 1 squares, 2 sum, 3 search
  logic        step_r, step_nxt;     // 0 square midpoint, 1 compare
  logic [14:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [14:0] mag_r [3];
  logic        done_r, done_nxt;
  logic [33:0] sq0_r, sq1_r, sq2_r;
  logic [29:0] asq_r;

  logic [14:0] mid;
  logic [15:0] sum_lh;
  logic [15:0] odd;
  logic [47:0] plo, phi;
  logic [65:0] lhs;
  logic [63:0] rhs;
  logic        le;

  assign sum_lh = {1'b0, lo_r} + {1'b0, hi_r} + 16'd1;
  assign mid    = sum_lh[15:1];
  assign odd    = {mid, 1'b0} - 16'd1;
  assign plo    = {18'd0, asq_r} * {30'd0, s_r[17:0]};
  assign phi    = {18'd0, asq_r} * {30'd0, s_r[35:18]};
  assign lhs    = {18'd0, plo} + {phi, 18'd0};
  assign rhs    = {vv_r[comp_r], 30'd0};
  assign le     = lhs <= {2'd0, rhs};

  // sequence squares, sum and three searches
  always_comb begin
    s_nxt = s_r;
    comp_nxt = comp_r;
    phase_nxt = phase_r;
    step_nxt = step_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    done_nxt = 1'b0;
    unique case (phase_r)
      2'd0: begin
        if (start) phase_nxt = 2'd1;
      end
      2'd1: phase_nxt = 2'd2;
      2'd2: begin
        s_nxt = {2'd0, sq0_r} + {2'd0, sq1_r} + {2'd0, sq2_r};
        comp_nxt = 2'd0;
        step_nxt = 1'b0;
        lo_nxt = 15'd0;
        hi_nxt = hnm_pkg::ONE_Q14;
        phase_nxt = 2'd3;
      end
      default: begin
        if (s_r == 36'd0) begin
          done_nxt = 1'b1;
          phase_nxt = 2'd0;
        end else if (lo_r == hi_r) begin
          if (comp_r == 2'd2) begin
            done_nxt = 1'b1;
            phase_nxt = 2'd0;
          end else begin
            comp_nxt = comp_r + 2'd1;
            lo_nxt = 15'd0;
            hi_nxt = hnm_pkg::ONE_Q14;
          end
        end else if (!step_r) begin
          step_nxt = 1'b1;
        end else begin
          step_nxt = 1'b0;
          if (le) lo_nxt = mid;
          else hi_nxt = mid - 15'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
      step_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
    s_r <= s_nxt;
    comp_r <= comp_nxt;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    // capture operands and square them
    if (phase_r == 2'd0 && start) begin
      m_r[0] <= req.vx[16] ? 17'(-req.vx) : 17'(req.vx);
      m_r[1] <= req.vy;
      m_r[2] <= req.vz[16] ? 17'(-req.vz) : 17'(req.vz);
      neg_r[0] <= req.vx[16];
      neg_r[1] <= 1'b0;
      neg_r[2] <= req.vz[16];
    end
    if (phase_r == 2'd1) begin
      sq0_r <= m_r[0] * m_r[0];
      sq1_r <= m_r[1] * m_r[1];
      sq2_r <= m_r[2] * m_r[2];
    end
    if (phase_r == 2'd2) begin
      vv_r[0] <= sq0_r;
      vv_r[1] <= sq1_r;
      vv_r[2] <= sq2_r;
    end
    // square the midpoint ahead of the compare
    if (phase_r == 2'd3 && !step_r) asq_r <= 30'(odd) * 30'(odd);
    if (phase_r == 2'd3 && lo_r == hi_r && s_r != 36'd0) mag_r[comp_r] <= lo_r;
  end

  // apply signs; zero vector gives straight up
  always_comb begin
    if (s_r == 36'd0) begin
      res.nx = 16'sd0;
      res.ny = hnm_pkg::ONE_Q14;
      res.nz = 16'sd0;
    end else begin
      res.nx = neg_r[0] ? -$signed({1'b0, mag_r[0]}) : $signed({1'b0, mag_r[0]});
      res.ny = mag_r[1];
      res.nz = neg_r[2] ? -$signed({1'b0, mag_r[2]}) : $signed({1'b0, mag_r[2]});
    end
  end

  assign done = done_r;

endmodule

[hdl/hnm_checker.sv]
// ----------------------------------------------------------------------------
// hnm_checker
// Port-level checks of the normal-map generator.
// ----------------------------------------------------------------------------
module hnm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast,
  input logic        cfg_ready
);

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");

  // frame end closes the item
  a_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("frame end without item end");

  // no input while a result waits
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready && !cfg_ready)
    else $error("input taken while result pending");

  // a taken height blocks the input on the next cycle
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input not held off after transaction");

  // y component never exceeds one
  a_ny: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[30:16] <= 15'd16384)
    else $error("y component out of range");

endmodule

bind heightfield_normal_map hnm_checker u_hnm_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser), .out_tlast(out_tlast), .cfg_ready(cfg_ready)
);
